// ===== rtl/core/bpdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdsc_pkg
// Shared types and constants for the dual-sensor brake pedal check.
// ----------------------------------------------------------------------------
package bpdsc_pkg;

    // Default values of the top-level parameters.
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 10;

    // Register field widths.
    localparam int REG_W    = 10;   // limit and delta registers
    localparam int TRIM_W   = 8;    // margin and trim registers
    localparam int ADDR_W   = 3;    // register index
    localparam int CFG_DW   = 10;   // configuration write data

    // Result beat layout, from the lowest bit up.
    localparam int PCT_W    = 7;    // position_percent
    localparam int MEAN_W   = 10;   // primary_mean
    localparam int FAULT_W  = 5;    // fault_mask
    localparam int OUT_W    = 24;   // fields padded to whole bytes

    // Percent scaling constants.
    localparam int PCT_SCALE = 100;
    localparam int PCT_MAX   = 76;
    localparam int QMOD_W    = 8;   // quotient is kept modulo 256

    // Register indexes.
    localparam logic [ADDR_W-1:0] REG_PRIMARY_LOW    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_PRIMARY_HIGH   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SECONDARY_LOW  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_SECONDARY_HIGH = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RANGE_MARGIN   = 3'd4;
    localparam logic [ADDR_W-1:0] REG_SCALE_TRIM     = 3'd5;
    localparam logic [ADDR_W-1:0] REG_DELTA_MIN      = 3'd6;
    localparam logic [ADDR_W-1:0] REG_DELTA_MAX      = 3'd7;

    // Reset values.
    localparam logic [REG_W-1:0]  RST_PRIMARY_LOW    = 10'd426;
    localparam logic [REG_W-1:0]  RST_PRIMARY_HIGH   = 10'd665;
    localparam logic [REG_W-1:0]  RST_SECONDARY_LOW  = 10'd455;
    localparam logic [REG_W-1:0]  RST_SECONDARY_HIGH = 10'd686;
    localparam logic [TRIM_W-1:0] RST_RANGE_MARGIN   = 8'd40;
    localparam logic [TRIM_W-1:0] RST_SCALE_TRIM     = 8'd3;
    localparam logic [REG_W-1:0]  RST_DELTA_MIN      = 10'd0;
    localparam logic [REG_W-1:0]  RST_DELTA_MAX      = 10'd30;

    typedef struct packed {
        logic [REG_W-1:0]  primary_low;
        logic [REG_W-1:0]  primary_high;
        logic [REG_W-1:0]  secondary_low;
        logic [REG_W-1:0]  secondary_high;
        logic [TRIM_W-1:0] range_margin;
        logic [TRIM_W-1:0] scale_trim;
        logic [REG_W-1:0]  delta_min;
        logic [REG_W-1:0]  delta_max;
    } cfg_t;

endpackage

// ===== rtl/core/bpdsc_ram.sv =====
// ----------------------------------------------------------------------------
// bpdsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpdsc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 10
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/bpdsc_cfg.sv =====
// ----------------------------------------------------------------------------
// bpdsc_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module bpdsc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [bpdsc_pkg::ADDR_W-1:0]   addr,
    input  logic [bpdsc_pkg::CFG_DW-1:0]   wdata,
    output bpdsc_pkg::cfg_t                cfg
);

    bpdsc_pkg::cfg_t cfg_reg;
    bpdsc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (addr)
                bpdsc_pkg::REG_PRIMARY_LOW:    cfg_next.primary_low    = wdata;
                bpdsc_pkg::REG_PRIMARY_HIGH:   cfg_next.primary_high   = wdata;
                bpdsc_pkg::REG_SECONDARY_LOW:  cfg_next.secondary_low  = wdata;
                bpdsc_pkg::REG_SECONDARY_HIGH: cfg_next.secondary_high = wdata;
                bpdsc_pkg::REG_RANGE_MARGIN:
                    cfg_next.range_margin = wdata[bpdsc_pkg::TRIM_W-1:0];
                bpdsc_pkg::REG_SCALE_TRIM:
                    cfg_next.scale_trim = wdata[bpdsc_pkg::TRIM_W-1:0];
                bpdsc_pkg::REG_DELTA_MIN:      cfg_next.delta_min      = wdata;
                bpdsc_pkg::REG_DELTA_MAX:      cfg_next.delta_max      = wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.primary_low    <= bpdsc_pkg::RST_PRIMARY_LOW;
            cfg_reg.primary_high   <= bpdsc_pkg::RST_PRIMARY_HIGH;
            cfg_reg.secondary_low  <= bpdsc_pkg::RST_SECONDARY_LOW;
            cfg_reg.secondary_high <= bpdsc_pkg::RST_SECONDARY_HIGH;
            cfg_reg.range_margin   <= bpdsc_pkg::RST_RANGE_MARGIN;
            cfg_reg.scale_trim     <= bpdsc_pkg::RST_SCALE_TRIM;
            cfg_reg.delta_min      <= bpdsc_pkg::RST_DELTA_MIN;
            cfg_reg.delta_max      <= bpdsc_pkg::RST_DELTA_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/bpdsc_div.sv =====
// ----------------------------------------------------------------------------
// bpdsc_div
// Iterative unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpdsc_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign busy   = (count_reg != '0);
    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (start) begin
            count_next = CNT_W'(NUM_W);
            rem_next   = '0;
            quo_next   = num;
            den_next   = den;
        end else if (busy) begin
            count_next = count_reg - CNT_W'(1);
            // The partial remainder stays below the divisor, so it fits DEN_W bits.
            rem_next   = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_next   = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quot = quo_reg;

endmodule

// ===== rtl/core/brake_pedal_dual_sensor_check_top.sv =====
// ----------------------------------------------------------------------------
// brake_pedal_dual_sensor_check_top
// Dual-sensor brake pedal plausibility check: moving averages, range and
// disagreement faults, and a scaled pedal position.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         primary_sample, secondary_sample (SAMPLE_BITS each)
//  m_axis    out        position_percent[6:0], primary_mean[9:0], fault_mask[4:0]
//  cfg       in         register index and write data, one write per cycle
//
//  Each sample pair passes from acceptance through ST_READ (window RAM
//  read), ST_MUL1, ST_MUL2 and ST_MUL3 (shared multiplier, both averages and
//  the times-100 step), ST_DIVLOAD (divider load), ST_DIVIDE and ST_FINISH
//  (result packing) before its result is offered, and the next pair is
//  accepted only once the block is back in ST_IDLE. The iterative percent
//  divider in ST_DIVIDE produces one quotient bit per cycle.
//  Reset needs no clearing pass: a flag marks the first full turn of the
//  window ring, and until then the slot being replaced reads as zero.
//  The result sits in an output register, so the next pair is accepted while
//  a finished result waits on m_axis_tready; a new result waits in the last
//  state only while the previous one has not been taken.
//
module brake_pedal_dual_sensor_check_top #(
    parameter int WINDOW      = bpdsc_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = bpdsc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Sample input: primary_sample, then secondary_sample, zero padded.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Result output: position_percent, primary_mean, fault_mask, zero padded.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [bpdsc_pkg::OUT_W-1:0]            m_axis_tdata,
    // Configuration write port.
    input  logic                                   cfg_wr_en,
    input  logic [bpdsc_pkg::ADDR_W-1:0]           cfg_addr,
    input  logic [bpdsc_pkg::CFG_DW-1:0]           cfg_wdata
);

    localparam int SB      = SAMPLE_BITS;
    localparam int L2W     = $clog2(WINDOW);
    localparam int TOT_W   = SB + L2W;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Floor division by WINDOW is a multiply by a rounded-up reciprocal,
    // exact for every total of TOT_W bits.
    localparam int SH      = TOT_W + L2W;
    localparam int REC_W   = TOT_W + 1;
    localparam logic [63:0] REC_VAL =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int WIDE_W  = (SB > bpdsc_pkg::REG_W) ? SB : bpdsc_pkg::REG_W;
    localparam int CMP_W   = WIDE_W + 2;
    localparam int DIFF_W  = WIDE_W + 1;
    localparam int NUM_W   = DIFF_W + bpdsc_pkg::PCT_W;
    localparam int DEN_W   = bpdsc_pkg::REG_W + 1;
    localparam int MA_W    = (TOT_W > DIFF_W) ? TOT_W : DIFF_W;
    localparam int MB_W    = (REC_W > bpdsc_pkg::PCT_W) ? REC_W : bpdsc_pkg::PCT_W;
    localparam int PROD_W  = MA_W + MB_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_READ    = 8'b0000_0010,
        ST_MUL1    = 8'b0000_0100,
        ST_MUL2    = 8'b0000_1000,
        ST_MUL3    = 8'b0001_0000,
        ST_DIVLOAD = 8'b0010_0000,
        ST_DIVIDE  = 8'b0100_0000,
        ST_FINISH  = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic                         wrapped_reg, wrapped_next;
    logic [TOT_W-1:0]             tot1_reg, tot1_next;
    logic [TOT_W-1:0]             tot2_reg, tot2_next;
    logic                         out_valid_reg, out_valid_next;

    logic [SB-1:0]                s1_reg, s1_next;
    logic [SB-1:0]                s2_reg, s2_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [SB-1:0]                avg1_reg, avg1_next;
    logic [SB-1:0]                avg2_reg, avg2_next;
    logic                         neg_reg, neg_next;
    logic [bpdsc_pkg::OUT_W-1:0]  out_data_reg, out_data_next;

    bpdsc_pkg::cfg_t              cfg;

    logic                         in_beat;
    logic [2*SB-1:0]              ram_rdata;
    logic [SB-1:0]                old1, old2;
    logic                         ram_we;

    logic [MA_W-1:0]              mul_a;
    logic [MB_W-1:0]              mul_b;

    logic [CMP_W-1:0]             sum_trim, low1_x, mag_full, span_full, span_diff;
    logic                         diff_neg, span_pos;
    logic [DIFF_W-1:0]            diff_mag;

    logic                         div_start, div_busy;
    logic [NUM_W-1:0]             div_quot;

    logic [bpdsc_pkg::QMOD_W-1:0] q_low, q_mod;
    logic [bpdsc_pkg::PCT_W-1:0]  percent;
    logic [CMP_W-1:0]             avg1_x, avg2_x, margin_x;
    logic                         lo1, hi1, lo2, hi2, disagree;
    logic [SB-1:0]                delta;
    logic [bpdsc_pkg::FAULT_W-1:0] fault;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    bpdsc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .addr    (cfg_addr),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    // Both sample rings share one RAM, primary sample in the low half.
    assign ram_we = (state_reg == ST_READ);

    bpdsc_ram #(
        .WIDTH (2*SB),
        .DEPTH (WINDOW)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({s2_reg, s1_reg}),
        .re    (in_beat),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Until the ring has turned once, the slot being replaced was never
    // written and holds a zero sample.
    assign old1 = wrapped_reg ? ram_rdata[SB-1:0]    : '0;
    assign old2 = wrapped_reg ? ram_rdata[2*SB-1:SB] : '0;

    // Offset and span for percent scaling. The offset avg1 - (low - trim) is
    // kept as a sign and a magnitude so that the divider works unsigned.
    assign low1_x    = CMP_W'(cfg.primary_low);
    assign sum_trim  = CMP_W'(avg1_reg) + CMP_W'(cfg.scale_trim);
    assign diff_neg  = (sum_trim < low1_x);
    assign mag_full  = diff_neg ? (low1_x - sum_trim) : (sum_trim - low1_x);
    assign diff_mag  = mag_full[DIFF_W-1:0];
    assign span_full = CMP_W'(cfg.primary_high) + (CMP_W'(cfg.scale_trim) << 1);
    assign span_pos  = (span_full > low1_x);
    assign span_diff = span_full - low1_x;

    // One multiplier serves both averages and the times-100 step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL1: begin
                mul_a = MA_W'(tot1_reg);
                mul_b = MB_W'(REC_VAL[REC_W-1:0]);
            end
            ST_MUL2: begin
                mul_a = MA_W'(tot2_reg);
                mul_b = MB_W'(REC_VAL[REC_W-1:0]);
            end
            ST_MUL3: begin
                mul_a = MA_W'(diff_mag);
                mul_b = MB_W'(bpdsc_pkg::PCT_SCALE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIVLOAD);

    bpdsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg[NUM_W-1:0]),
        .den     (span_diff[DEN_W-1:0]),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // The signed quotient is taken modulo 256, then anything above the
    // cutoff, or any result of a non-positive span, reads as zero.
    assign q_low   = div_quot[bpdsc_pkg::QMOD_W-1:0];
    assign q_mod   = neg_reg ? (~q_low + bpdsc_pkg::QMOD_W'(1)) : q_low;
    assign percent = (span_pos && (q_mod <= bpdsc_pkg::QMOD_W'(bpdsc_pkg::PCT_MAX)))
                     ? q_mod[bpdsc_pkg::PCT_W-1:0] : '0;

    // Range checks: the high check only counts when the low flag is clear.
    assign avg1_x   = CMP_W'(avg1_reg);
    assign avg2_x   = CMP_W'(avg2_reg);
    assign margin_x = CMP_W'(cfg.range_margin);
    assign lo1 = ((avg1_x + margin_x) < CMP_W'(cfg.primary_low));
    assign hi1 = !lo1 && (avg1_x > (CMP_W'(cfg.primary_high) + margin_x));
    assign lo2 = ((avg2_x + margin_x) < CMP_W'(cfg.secondary_low));
    assign hi2 = !lo2 && (avg2_x > (CMP_W'(cfg.secondary_high) + margin_x));
    assign delta = (avg1_reg >= avg2_reg) ? (avg1_reg - avg2_reg) : (avg2_reg - avg1_reg);
    assign disagree = (CMP_W'(delta) < CMP_W'(cfg.delta_min)) ||
                      (CMP_W'(delta) > CMP_W'(cfg.delta_max));
    assign fault = {disagree, hi2, lo2, hi1, lo1};

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        wrapped_next   = wrapped_reg;
        tot1_next      = tot1_reg;
        tot2_next      = tot2_reg;
        out_valid_next = out_valid_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        prod_next      = prod_reg;
        avg1_next      = avg1_reg;
        avg2_next      = avg2_reg;
        neg_next       = neg_reg;
        out_data_next  = out_data_reg;

        // A waiting result leaves once the downstream side takes the beat.
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    s1_next    = s_axis_tdata[SB-1:0];
                    s2_next    = s_axis_tdata[2*SB-1:SB];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // Running totals swap the oldest sample for the new one.
                tot1_next = tot1_reg - TOT_W'(old1) + TOT_W'(s1_reg);
                tot2_next = tot2_reg - TOT_W'(old2) + TOT_W'(s2_reg);
                if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                    slot_next    = '0;
                    wrapped_next = 1'b1;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                avg1_next  = prod_reg[SH +: SB];
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                avg2_next  = prod_reg[SH +: SB];
                neg_next   = diff_neg;
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = ST_DIVLOAD;
            end
            ST_DIVLOAD: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!div_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = bpdsc_pkg::OUT_W'({fault,
                                                        bpdsc_pkg::MEAN_W'(avg1_reg),
                                                        percent});
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            wrapped_reg   <= 1'b0;
            tot1_reg      <= '0;
            tot2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            wrapped_reg   <= wrapped_next;
            tot1_reg      <= tot1_next;
            tot2_reg      <= tot2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        prod_reg     <= prod_next;
        avg1_reg     <= avg1_next;
        avg2_reg     <= avg2_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/bpdsc_checker.sv =====
// ----------------------------------------------------------------------------
// bpdsc_checker
// Port-level assertions for the brake pedal check, bound to the top level.
// ----------------------------------------------------------------------------
module bpdsc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [bpdsc_pkg::OUT_W-1:0] m_axis_tdata
);

    // A stalled result beat keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // The block works on one pair at a time.
    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a pair is in progress");

    // No result is offered right after an input beat: the work takes cycles.
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared without processing time");

    // Position never exceeds the cutoff and the padding stays zero.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[6:0] <= 7'd76) &&
                           (m_axis_tdata[bpdsc_pkg::OUT_W-1:22] == '0)))
        else $error("result beat out of range");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind brake_pedal_dual_sensor_check_top bpdsc_checker u_bpdsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
